[rtl/wtc_pkg.sv]
// Shared types and constants of the whitespace token classifier.
package wtc_pkg;

  localparam int DEF_MAX_TOKEN_LEN = 64;
  localparam int PREFIX_DEPTH      = 6;
  localparam int TOK_LEN_W         = 7;

  typedef enum logic [3:0] {
    CLS_KEYWORD = 4'd0,
    CLS_VARTYPE = 4'd1,
    CLS_ARITH   = 4'd2,
    CLS_ASSIGN  = 4'd3,
    CLS_COMPARE = 4'd4,
    CLS_LBRACE  = 4'd5,
    CLS_RBRACE  = 4'd6,
    CLS_LPAREN  = 4'd7,
    CLS_RPAREN  = 4'd8,
    CLS_TERM    = 4'd9,
    CLS_SEP     = 4'd10,
    CLS_INT     = 4'd11,
    CLS_ID      = 4'd12,
    CLS_STRING  = 4'd13,
    CLS_ERROR   = 4'd14,
    CLS_END     = 4'd15
  } tok_class_t;

  // Lexeme summary handed to the classifier; len_code is the length when
  // it is at most six and 7 for anything longer.
  typedef struct packed {
    logic [PREFIX_DEPTH-1:0][7:0] prefix;
    logic [2:0]                   len_code;
    logic                         inside_quotes;
    logic                         identifier_ok;
    logic                         integer_ok;
    logic                         digit_seen;
  } lex_state_t;

endpackage

[rtl/wtc_channels.sv]
// Handshake channels of the token classifier: byte input and token result.
interface wtc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_input;

  modport source (output valid, output char_code, output end_of_input, input ready);
  modport sink   (input valid, input char_code, input end_of_input, output ready);
endinterface

interface wtc_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] token_class;
  logic [6:0] token_length;
  logic       too_long;
  logic       last;

  modport source (output valid, output token_class, output token_length,
                  output too_long, output last, input ready);
  modport sink   (input valid, input token_class, input token_length,
                  input too_long, input last, output ready);
endinterface

[rtl/wtc_lexeme.sv]
// Lexeme tracker: prefix bytes, length counter and per-byte class flags.
module wtc_lexeme #(
  parameter int MAX_TOKEN_LEN = wtc_pkg::DEF_MAX_TOKEN_LEN
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   adv,
  input  logic [7:0]                             char_code,
  input  logic                                   end_of_input,
  output wtc_pkg::lex_state_t                    st,
  output logic [$clog2(MAX_TOKEN_LEN+1)-1:0]     len,
  output logic                                   overflow,
  output logic                                   delim
);
  import wtc_pkg::*;

  localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  logic [PREFIX_DEPTH-1:0][7:0] prefix_r;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic inq_r, inq_nxt;
  logic id_ok_r, id_ok_nxt;
  logic int_ok_r, int_ok_nxt;
  logic dig_r, dig_nxt;
  logic ovf_r, ovf_nxt;
  logic is_digit, is_letter, len_zero;

  assign is_digit  = (char_code >= 8'h30) && (char_code <= 8'h39);
  assign is_letter = ((char_code >= 8'h41) && (char_code <= 8'h5A)) ||
                     ((char_code >= 8'h61) && (char_code <= 8'h7A));
  assign len_zero  = (len_r == '0);

  // delimiters inside quotes are ordinary bytes
  assign delim = end_of_input ||
                 (!inq_r && ((char_code == CH_SPACE) || (char_code == CH_TAB) ||
                             (char_code == CH_LF)));

  always_comb begin
    len_nxt    = len_r;
    inq_nxt    = inq_r;
    id_ok_nxt  = id_ok_r;
    int_ok_nxt = int_ok_r;
    dig_nxt    = dig_r;
    ovf_nxt    = ovf_r;
    if (adv) begin
      if (delim) begin
        len_nxt    = '0;
        inq_nxt    = 1'b0;
        id_ok_nxt  = 1'b1;
        int_ok_nxt = 1'b1;
        dig_nxt    = 1'b0;
        ovf_nxt    = 1'b0;
      end else begin
        if (len_zero) begin
          id_ok_nxt  = is_letter;
          int_ok_nxt = (char_code == CH_MINUS) || is_digit;
        end else begin
          id_ok_nxt  = id_ok_r && (is_letter || is_digit);
          int_ok_nxt = int_ok_r && is_digit;
        end
        if (is_digit) dig_nxt = 1'b1;
        if (char_code == CH_QUOTE) inq_nxt = !inq_r;
        if (len_r < LEN_W'(MAX_TOKEN_LEN)) len_nxt = len_r + LEN_W'(1);
        else ovf_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r    <= '0;
      inq_r    <= 1'b0;
      id_ok_r  <= 1'b1;
      int_ok_r <= 1'b1;
      dig_r    <= 1'b0;
      ovf_r    <= 1'b0;
    end else begin
      len_r    <= len_nxt;
      inq_r    <= inq_nxt;
      id_ok_r  <= id_ok_nxt;
      int_ok_r <= int_ok_nxt;
      dig_r    <= dig_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

  // only the first PREFIX_DEPTH bytes are kept; no reset, entries are written before use
  always_ff @(posedge clk) begin
    if (adv && !delim && (len_r < LEN_W'(PREFIX_DEPTH))) begin
      prefix_r[len_r[2:0]] <= char_code;
    end
  end

  always_comb begin
    st.prefix        = prefix_r;
    st.len_code      = (len_r < LEN_W'(7)) ? len_r[2:0] : 3'd7;
    st.inside_quotes = inq_r;
    st.identifier_ok = id_ok_r;
    st.integer_ok    = int_ok_r;
    st.digit_seen    = dig_r;
  end

  assign len      = len_r;
  assign overflow = ovf_r;

endmodule

[rtl/wtc_classify.sv]
// Token classifier: matches the kept prefix against the fixed tokens, else uses the lexeme flags.
module wtc_classify (
  input  wtc_pkg::lex_state_t st,
  output wtc_pkg::tok_class_t cls
);
  import wtc_pkg::*;

  // Tokens are right-aligned string literals of n bytes.
  function automatic logic tok_is(lex_state_t s, int unsigned n, logic [47:0] tok);
    logic [47:0] la;
    logic        hit;
    la  = tok << (8 * (PREFIX_DEPTH - n));
    hit = (s.len_code == 3'(n));
    for (int i = 0; i < PREFIX_DEPTH; i++) begin
      if ((i < n) && (s.prefix[i] != la[47 - 8*i -: 8])) hit = 1'b0;
    end
    return hit;
  endfunction

  logic kw, vt, ar, cmp;

  assign kw  = tok_is(st, 2, 48'("if"))     || tok_is(st, 2, 48'("IF"))     ||
               tok_is(st, 4, 48'("else"))   || tok_is(st, 4, 48'("ELSE"))   ||
               tok_is(st, 5, 48'("while"))  || tok_is(st, 5, 48'("WHILE"))  ||
               tok_is(st, 6, 48'("return")) || tok_is(st, 6, 48'("RETURN"));
  assign vt  = tok_is(st, 3, 48'("int"))  || tok_is(st, 3, 48'("INT")) ||
               tok_is(st, 4, 48'("char")) || tok_is(st, 4, 48'("CHAR"));
  assign ar  = tok_is(st, 1, 48'("+")) || tok_is(st, 1, 48'("-")) ||
               tok_is(st, 1, 48'("*")) || tok_is(st, 1, 48'("/"));
  assign cmp = tok_is(st, 1, 48'("<"))  || tok_is(st, 1, 48'(">"))  ||
               tok_is(st, 2, 48'("==")) || tok_is(st, 2, 48'("!=")) ||
               tok_is(st, 2, 48'("<=")) || tok_is(st, 2, 48'(">="));

  always_comb begin
    if (st.inside_quotes)                  cls = CLS_ERROR;
    else if (st.prefix[0] == 8'h22)        cls = CLS_STRING;
    else if (kw)                           cls = CLS_KEYWORD;
    else if (vt)                           cls = CLS_VARTYPE;
    else if (ar)                           cls = CLS_ARITH;
    else if (tok_is(st, 1, 48'("=")))      cls = CLS_ASSIGN;
    else if (cmp)                          cls = CLS_COMPARE;
    else if (tok_is(st, 1, 48'("{")))      cls = CLS_LBRACE;
    else if (tok_is(st, 1, 48'("}")))      cls = CLS_RBRACE;
    else if (tok_is(st, 1, 48'("(")))      cls = CLS_LPAREN;
    else if (tok_is(st, 1, 48'(")")))      cls = CLS_RPAREN;
    else if (tok_is(st, 1, 48'(";")))      cls = CLS_TERM;
    else if (tok_is(st, 1, 48'(",")))      cls = CLS_SEP;
    else if (st.integer_ok && st.digit_seen) cls = CLS_INT;
    else if (st.identifier_ok)             cls = CLS_ID;
    else                                   cls = CLS_ERROR;
  end

endmodule

[rtl/whitespace_token_classifier.sv]
// Byte-stream tokenizer: one byte item per cycle in, one token item per
// finished lexeme out. Each byte passes an input register, then the lexeme
// tracker and classifier, then the result register that holds the token; the
// sustained rate is one byte per clock, held back only by a stalled result
// register. Lexemes split on space, tab and newline outside double quotes;
// end_of_input closes the stream and always yields a token marked last
// (class 15 if nothing is pending). Lengths saturate at MAX_TOKEN_LEN with
// too_long set.
module whitespace_token_classifier #(
  parameter int MAX_TOKEN_LEN = wtc_pkg::DEF_MAX_TOKEN_LEN
) (
  input  logic             clk,
  input  logic             rst_n,
  wtc_in_if.sink           in_ch,
  wtc_out_if.source        out_ch
);
  import wtc_pkg::*;

  localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);

  logic       a_valid_r, a_valid_nxt;
  logic [7:0] a_char_r;
  logic       a_eoi_r;
  logic       out_valid_r, out_valid_nxt;
  logic [3:0] out_cls_r;
  logic [6:0] out_len_r;
  logic       out_long_r;
  logic       out_last_r;

  logic       out_free, a_adv, in_fire, emit, delim, overflow;
  logic [LEN_W-1:0] len;
  lex_state_t st;
  tok_class_t cls;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign a_adv       = a_valid_r && out_free;
  assign in_ch.ready = !a_valid_r || out_free;
  assign in_fire     = in_ch.valid && in_ch.ready;

  wtc_lexeme #(.MAX_TOKEN_LEN(MAX_TOKEN_LEN)) u_lexeme (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (a_adv),
    .char_code    (a_char_r),
    .end_of_input (a_eoi_r),
    .st           (st),
    .len          (len),
    .overflow     (overflow),
    .delim        (delim)
  );

  wtc_classify u_classify (
    .st  (st),
    .cls (cls)
  );

  // a delimiter with nothing pending is dropped unless it ends the stream
  assign emit = a_adv && delim && ((len != '0) || a_eoi_r);

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (in_fire)    a_valid_nxt = 1'b1;
    else if (a_adv) a_valid_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    if (emit)              out_valid_nxt = 1'b1;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      a_valid_r   <= a_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_char_r <= in_ch.char_code;
      a_eoi_r  <= in_ch.end_of_input;
    end
    if (emit) begin
      if (len == '0) begin
        out_cls_r  <= CLS_END;
        out_len_r  <= '0;
        out_long_r <= 1'b0;
      end else begin
        out_cls_r  <= cls;
        out_len_r  <= TOK_LEN_W'(len);
        out_long_r <= overflow;
      end
      out_last_r <= a_eoi_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.token_class  = out_cls_r;
  assign out_ch.token_length = out_len_r;
  assign out_ch.too_long     = out_long_r;
  assign out_ch.last         = out_last_r;

endmodule

[rtl/wtc_checker.sv]
// Port-level checks of the token classifier, bound to the top level.
module wtc_checker #(
  parameter int MAX_TOKEN_LEN = wtc_pkg::DEF_MAX_TOKEN_LEN
) (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] out_token_class,
  input logic [6:0] out_token_length,
  input logic       out_too_long,
  input logic       out_last
);
  import wtc_pkg::*;

  localparam logic [6:0] SAT_LEN = 7'(MAX_TOKEN_LEN);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_token_class) &&
    $stable(out_token_length) && $stable(out_too_long) && $stable(out_last))
    else $error("token item changed while stalled");

  a_end_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_token_class == CLS_END) |->
    out_last && (out_token_length == 7'd0) && !out_too_long)
    else $error("end token with length, overflow or without last");

  a_end_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> (out_token_class != CLS_END))
    else $error("end token before end of stream");

  a_sat_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_too_long |->
    (out_token_length == SAT_LEN) && (out_token_class != CLS_END))
    else $error("overlong token not saturated");

endmodule

bind whitespace_token_classifier wtc_checker #(.MAX_TOKEN_LEN(MAX_TOKEN_LEN)) u_wtc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_token_class  (out_ch.token_class),
  .out_token_length (out_ch.token_length),
  .out_too_long     (out_ch.too_long),
  .out_last         (out_ch.last)
);
